/* rtl/rtm_pkg.sv */
// ----------------------------------------------------------------------------
// rtm_pkg
// shared widths, codes and controller/datapath interface types of the
// region table manager
// ----------------------------------------------------------------------------
package rtm_pkg;

	localparam int MAX_REGIONS = 16;
	localparam int ADDR_W      = 48;
	localparam int LEN_W       = ADDR_W + 1;
	localparam int END_W       = ADDR_W + 2;
	localparam int CL_W        = ADDR_W + 3;
	localparam int FLAG_W      = 2;
	localparam int KIND_W      = 3;
	localparam int ST_W        = 3;
	localparam int PAGE_BITS   = 12;
	localparam int IDX_W       = $clog2(MAX_REGIONS);
	localparam int CNT_W       = IDX_W + 1;

	localparam int IN_W   = ADDR_W + LEN_W + FLAG_W;
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W  = ST_W + ADDR_W + LEN_W + FLAG_W;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	localparam int CFG_DW = 64;
	localparam int CFG_AW = 4;

	localparam logic [LEN_W-1:0]  PAGE_MASK  = LEN_W'((64'd1 << PAGE_BITS) - 64'd1);
	localparam logic [ADDR_W-1:0] LOW_RESET  = ADDR_W'(64'h1000);
	localparam logic [LEN_W-1:0]  HIGH_RESET = LEN_W'(64'h8000_0000_0000);

	// request kinds
	localparam logic [KIND_W-1:0] KIND_FIND     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INS_AT   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INS_ANY  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_VALIDATE = 3'd4;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 3'd0,
		ST_MISS    = 3'd1,
		ST_ALIGN   = 3'd2,
		ST_OVERLAP = 3'd3,
		ST_NOSPACE = 3'd4,
		ST_FULL    = 3'd5
	} status_t;

	typedef enum logic [1:0] {RD_NONE, RD_I, RD_JM1, RD_JP1} rd_sel_t;
	typedef enum logic [2:0] {WR_NONE, WR_MOVE, WR_INS, WR_TRIM, WR_CUT} wr_sel_t;
	typedef enum logic [1:0] {INS_NONE, INS_REQ, INS_CAND, INS_SPLIT} ins_sel_t;
	typedef enum logic [2:0] {J_HOLD, J_CNT, J_I, J_DEC, J_INC} j_op_t;
	typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;
	typedef enum logic [1:0] {SRC_ZERO, SRC_ENTRY, SRC_INS} src_t;

	typedef struct packed {
		logic     load;
		rd_sel_t  rd;
		wr_sel_t  wr;
		ins_sel_t ins;
		j_op_t    j_op;
		cnt_op_t  cnt_op;
		logic     i_inc;
		logic     cand_upd;
		logic     base_upd;
		logic     res_we;
		status_t  res_st;
		src_t     res_src;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic i_end;
		logic full;
		logic j_gt_pos;
		logic jp1_lt_cnt;
		logic addr_mis;
		logic len_mis;
		logic b_gt_base;
		logic e_gt_base;
		logic b_ge_lim;
		logic e_gt_addr;
		logic b_ge_addr;
		logic e_gt_lim;
		logic e_ge_lim;
		logic b_ge_candlen;
		logic high_lt_candlen;
		logic cand_big;
		logic lim_big;
		logic out_busy;
	} sts_t;

endpackage

/* rtl/rtm_regs.sv */
// ----------------------------------------------------------------------------
// rtm_regs
// configuration registers behind the apb port
// ----------------------------------------------------------------------------
module rtm_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [rtm_pkg::CFG_AW-1:0] paddr,
	input  logic [rtm_pkg::CFG_DW-1:0] pwdata,
	output logic [rtm_pkg::CFG_DW-1:0] prdata,
	output logic                      pready,
	output logic [rtm_pkg::ADDR_W-1:0] low_limit,
	output logic [rtm_pkg::LEN_W-1:0]  high_limit
);
	import rtm_pkg::*;

	logic [ADDR_W-1:0] low_q;
	logic [LEN_W-1:0]  high_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register select on address bit 3 (8-byte spacing)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_RESET;
			high_q <= HIGH_RESET;
		end else if (wr_en) begin
			if (paddr[3]) begin
				high_q <= pwdata[LEN_W-1:0];
			end else begin
				low_q <= pwdata[ADDR_W-1:0];
			end
		end
	end

	assign prdata     = paddr[3] ? CFG_DW'(high_q) : CFG_DW'(low_q);
	assign low_limit  = low_q;
	assign high_limit = high_q;

endmodule

/* rtl/rtm_datapath.sv */
// ----------------------------------------------------------------------------
// rtm_datapath
// region table storage, request registers, compares and result register
// ----------------------------------------------------------------------------
module rtm_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rtm_pkg::KIND_W-1:0] in_kind,
	input  logic [rtm_pkg::IN_TW-1:0]  in_data,
	input  logic [rtm_pkg::ADDR_W-1:0] low_limit,
	input  logic [rtm_pkg::LEN_W-1:0]  high_limit,
	input  rtm_pkg::cmd_t              cmd,
	output rtm_pkg::sts_t              sts,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rtm_pkg::OUT_TW-1:0] out_data
);
	import rtm_pkg::*;

	// table storage
	logic [ADDR_W-1:0] mem_b [MAX_REGIONS];
	logic [LEN_W-1:0]  mem_l [MAX_REGIONS];
	logic [FLAG_W-1:0] mem_f [MAX_REGIONS];

	logic [KIND_W-1:0] kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [FLAG_W-1:0] fl_q;
	logic [END_W-1:0]  lim_q;
	logic [END_W-1:0]  base_q;
	logic [END_W-1:0]  cand_q;
	logic [CNT_W-1:0]  i_q, j_q, pos_q, cnt_q;
	logic [ADDR_W-1:0] ins_b_q;
	logic [LEN_W-1:0]  ins_l_q;
	logic [FLAG_W-1:0] ins_f_q;
	logic [ADDR_W-1:0] rd_b_q;
	logic [LEN_W-1:0]  rd_l_q;
	logic [FLAG_W-1:0] rd_f_q;
	logic [END_W-1:0]  rd_e_q;
	logic              out_vld_q;
	logic [OUT_W-1:0]  out_q;

	logic [CNT_W-1:0]  j_m1, j_p1;
	logic [CL_W-1:0]   candlen;
	logic [END_W-1:0]  rd_b_ext;
	logic [LEN_W-1:0]  trim_len, cut_len;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_idx;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [ADDR_W-1:0] wr_b;
	logic [LEN_W-1:0]  wr_l;
	logic [FLAG_W-1:0] wr_f;

	assign j_m1     = j_q - CNT_W'(1);
	assign j_p1     = j_q + CNT_W'(1);
	assign rd_b_ext = END_W'(rd_b_q);
	assign candlen  = CL_W'(cand_q) + CL_W'(len_q);
	assign trim_len = LEN_W'(addr_q - rd_b_q);
	assign cut_len  = LEN_W'(rd_e_q - lim_q);

	// read port select
	always_comb begin
		rd_en  = 1'b1;
		rd_idx = i_q[IDX_W-1:0];
		unique case (cmd.rd)
			RD_NONE: rd_en  = 1'b0;
			RD_I:    rd_idx = i_q[IDX_W-1:0];
			RD_JM1:  rd_idx = j_m1[IDX_W-1:0];
			RD_JP1:  rd_idx = j_p1[IDX_W-1:0];
			default: rd_en  = 1'b0;
		endcase
	end

	// write port select
	always_comb begin
		wr_en  = 1'b1;
		wr_idx = i_q[IDX_W-1:0];
		wr_b   = rd_b_q;
		wr_l   = rd_l_q;
		wr_f   = rd_f_q;
		unique case (cmd.wr)
			WR_NONE: wr_en = 1'b0;
			WR_MOVE: wr_idx = j_q[IDX_W-1:0];
			WR_INS: begin
				wr_idx = pos_q[IDX_W-1:0];
				wr_b   = ins_b_q;
				wr_l   = ins_l_q;
				wr_f   = ins_f_q;
			end
			WR_TRIM: wr_l = trim_len;
			WR_CUT: begin
				wr_b = lim_q[ADDR_W-1:0];
				wr_l = cut_len;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_b[wr_idx] <= wr_b;
			mem_l[wr_idx] <= wr_l;
			mem_f[wr_idx] <= wr_f;
		end
	end

	// registered read, end of entry formed alongside
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_b_q <= mem_b[rd_idx];
			rd_l_q <= mem_l[rd_idx];
			rd_f_q <= mem_f[rd_idx];
			rd_e_q <= END_W'(mem_b[rd_idx]) + END_W'(mem_l[rd_idx]);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			i_q       <= '0;
			j_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				i_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= i_q + CNT_W'(1);
			end
			unique case (cmd.j_op)
				J_HOLD:  j_q <= j_q;
				J_CNT:   j_q <= cnt_q;
				J_I:     j_q <= i_q;
				J_DEC:   j_q <= j_m1;
				J_INC:   j_q <= j_p1;
				default: j_q <= j_q;
			endcase
			unique case (cmd.cnt_op)
				CNT_HOLD: cnt_q <= cnt_q;
				CNT_INC:  cnt_q <= cnt_q + CNT_W'(1);
				CNT_DEC:  cnt_q <= cnt_q - CNT_W'(1);
				default:  cnt_q <= cnt_q;
			endcase
			if (cmd.res_we) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// request and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			addr_q <= in_data[ADDR_W-1:0];
			len_q  <= in_data[ADDR_W +: LEN_W];
			fl_q   <= in_data[ADDR_W+LEN_W +: FLAG_W];
			lim_q  <= END_W'(in_data[ADDR_W-1:0]) + END_W'(in_data[ADDR_W +: LEN_W]);
			base_q <= END_W'(in_data[ADDR_W-1:0]);
			cand_q <= END_W'(low_limit);
		end else begin
			if (cmd.cand_upd) begin
				cand_q <= rd_e_q;
			end
			if (cmd.base_upd) begin
				base_q <= rd_e_q;
			end
		end
		unique case (cmd.ins)
			INS_NONE: ;
			INS_REQ: begin
				ins_b_q <= addr_q;
				ins_l_q <= len_q;
				ins_f_q <= fl_q;
				pos_q   <= i_q;
			end
			INS_CAND: begin
				ins_b_q <= cand_q[ADDR_W-1:0];
				ins_l_q <= len_q;
				ins_f_q <= fl_q;
				pos_q   <= i_q;
			end
			INS_SPLIT: begin
				ins_b_q <= lim_q[ADDR_W-1:0];
				ins_l_q <= cut_len;
				ins_f_q <= rd_f_q;
				pos_q   <= i_q + CNT_W'(1);
			end
			default: ;
		endcase
		if (cmd.res_we) begin
			unique case (cmd.res_src)
				SRC_ZERO:  out_q <= {FLAG_W'(0), LEN_W'(0), ADDR_W'(0), cmd.res_st};
				SRC_ENTRY: out_q <= {rd_f_q, rd_l_q, rd_b_q, cmd.res_st};
				SRC_INS:   out_q <= {ins_f_q, ins_l_q, ins_b_q, cmd.res_st};
				default:   out_q <= {FLAG_W'(0), LEN_W'(0), ADDR_W'(0), cmd.res_st};
			endcase
		end
	end

	// status toward the controller
	always_comb begin
		sts.kind            = kind_q;
		sts.i_end           = i_q >= cnt_q;
		sts.full            = cnt_q >= CNT_W'(MAX_REGIONS);
		sts.j_gt_pos        = j_q > pos_q;
		sts.jp1_lt_cnt      = j_p1 < cnt_q;
		sts.addr_mis        = |(LEN_W'(addr_q) & PAGE_MASK);
		sts.len_mis         = |(len_q & PAGE_MASK);
		sts.b_gt_base       = rd_b_ext > base_q;
		sts.e_gt_base       = rd_e_q > base_q;
		sts.b_ge_lim        = rd_b_ext >= lim_q;
		sts.e_gt_addr       = rd_e_q > END_W'(addr_q);
		sts.b_ge_addr       = rd_b_q >= addr_q;
		sts.e_gt_lim        = rd_e_q > lim_q;
		sts.e_ge_lim        = rd_e_q >= lim_q;
		sts.b_ge_candlen    = CL_W'(rd_b_q) >= candlen;
		sts.high_lt_candlen = CL_W'(high_limit) < candlen;
		sts.cand_big        = |cand_q[END_W-1:ADDR_W];
		sts.lim_big         = |lim_q[END_W-1:ADDR_W];
		sts.out_busy        = out_vld_q;
	end

	assign out_valid = out_vld_q;
	assign out_data  = OUT_TW'(out_q);

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_REGIONS))
		else $error("region count above table size");

	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr == WR_INS) |-> !sts.full)
		else $error("insert into full table");

	a_res_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_we |-> !out_vld_q)
		else $error("result written while previous one pending");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cnt_op == CNT_HOLD) |=> $stable(cnt_q))
		else $error("region count changed without command");

endmodule

/* rtl/rtm_ctrl.sv */
// ----------------------------------------------------------------------------
// rtm_ctrl
// request sequencer: walks the table, opens and closes slots, issues result
// ----------------------------------------------------------------------------
module rtm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rtm_pkg::sts_t  sts,
	output rtm_pkg::cmd_t  cmd
);
	import rtm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_DONE,
		S_F_CHK, S_F_EV, S_V_EV, S_V_CHK, S_V_RD,
		S_IA_CHK, S_IA_EV, S_IA_GO,
		S_IW_CHK, S_IW_EV, S_IW_END,
		S_OS_CHK, S_OS_MV,
		S_RM_CHK, S_RM_EV,
		S_CS_CHK, S_CS_MV
	} state_t;

	state_t  state_q, state_d;
	status_t st_q, st_d;
	src_t    src_q, src_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.rd       = RD_NONE;
		cmd.wr       = WR_NONE;
		cmd.ins      = INS_NONE;
		cmd.j_op     = J_HOLD;
		cmd.cnt_op   = CNT_HOLD;
		cmd.res_st   = st_q;
		cmd.res_src  = src_q;
		state_d      = state_q;
		st_d         = st_q;
		src_d        = src_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_DONE;
				st_d    = ST_MISS;
				src_d   = SRC_ZERO;
				unique case (sts.kind)
					KIND_FIND, KIND_VALIDATE: state_d = S_F_CHK;
					KIND_INS_AT: begin
						if (sts.addr_mis) begin
							st_d = ST_ALIGN;
						end else begin
							state_d = S_IA_CHK;
						end
					end
					KIND_INS_ANY: state_d = S_IW_CHK;
					KIND_REMOVE: begin
						if (sts.addr_mis || sts.len_mis) begin
							st_d = ST_ALIGN;
						end else begin
							state_d = S_RM_CHK;
						end
					end
					default: st_d = ST_MISS;
				endcase
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.res_we = 1'b1;
					state_d    = S_IDLE;
				end
			end
			// locate region holding the address
			S_F_CHK: begin
				if (sts.i_end) begin
					state_d = S_DONE;
					st_d    = ST_MISS;
					src_d   = SRC_ZERO;
				end else begin
					cmd.rd  = RD_I;
					state_d = S_F_EV;
				end
			end
			S_F_EV: begin
				priority if (sts.b_gt_base) begin
					state_d = S_DONE;
					st_d    = ST_MISS;
					src_d   = SRC_ZERO;
				end else if (sts.e_gt_base) begin
					if (sts.kind == KIND_FIND) begin
						state_d = S_DONE;
						st_d    = ST_OK;
						src_d   = SRC_ENTRY;
					end else begin
						state_d = S_V_EV;
					end
				end else begin
					cmd.i_inc = 1'b1;
					state_d   = S_F_CHK;
				end
			end
			// coverage walk over adjacent regions
			S_V_EV: begin
				if (sts.e_ge_lim) begin
					state_d = S_DONE;
					st_d    = ST_OK;
					src_d   = SRC_ZERO;
				end else begin
					cmd.base_upd = 1'b1;
					cmd.i_inc    = 1'b1;
					state_d      = S_V_CHK;
				end
			end
			S_V_CHK: begin
				if (sts.i_end) begin
					state_d = S_DONE;
					st_d    = ST_MISS;
					src_d   = SRC_ZERO;
				end else begin
					cmd.rd  = RD_I;
					state_d = S_V_RD;
				end
			end
			S_V_RD: begin
				if (sts.b_gt_base) begin
					state_d = S_DONE;
					st_d    = ST_MISS;
					src_d   = SRC_ZERO;
				end else begin
					state_d = S_V_EV;
				end
			end
			// insert at fixed address
			S_IA_CHK: begin
				if (sts.i_end) begin
					state_d = S_IA_GO;
				end else begin
					cmd.rd  = RD_I;
					state_d = S_IA_EV;
				end
			end
			S_IA_EV: begin
				priority if (sts.b_ge_lim) begin
					state_d = S_IA_GO;
				end else if (sts.e_gt_addr) begin
					state_d = S_DONE;
					st_d    = ST_OVERLAP;
					src_d   = SRC_ZERO;
				end else begin
					cmd.i_inc = 1'b1;
					state_d   = S_IA_CHK;
				end
			end
			S_IA_GO: begin
				if (sts.full) begin
					state_d = S_DONE;
					st_d    = ST_FULL;
					src_d   = SRC_ZERO;
				end else begin
					cmd.ins  = INS_REQ;
					cmd.j_op = J_CNT;
					st_d     = ST_OK;
					src_d    = SRC_INS;
					state_d  = S_OS_CHK;
				end
			end
			// first-fit placement
			S_IW_CHK: begin
				if (sts.i_end) begin
					state_d = S_IW_END;
				end else begin
					cmd.rd  = RD_I;
					state_d = S_IW_EV;
				end
			end
			S_IW_EV: begin
				if (sts.b_ge_candlen) begin
					state_d = S_IW_END;
				end else begin
					cmd.cand_upd = 1'b1;
					cmd.i_inc    = 1'b1;
					state_d      = S_IW_CHK;
				end
			end
			S_IW_END: begin
				priority if ((sts.i_end && sts.high_lt_candlen) || sts.cand_big) begin
					state_d = S_DONE;
					st_d    = ST_NOSPACE;
					src_d   = SRC_ZERO;
				end else if (sts.full) begin
					state_d = S_DONE;
					st_d    = ST_FULL;
					src_d   = SRC_ZERO;
				end else begin
					cmd.ins  = INS_CAND;
					cmd.j_op = J_CNT;
					st_d     = ST_OK;
					src_d    = SRC_INS;
					state_d  = S_OS_CHK;
				end
			end
			// open a slot: shift entries up one at a time
			S_OS_CHK: begin
				if (sts.j_gt_pos) begin
					cmd.rd  = RD_JM1;
					state_d = S_OS_MV;
				end else begin
					cmd.wr     = WR_INS;
					cmd.cnt_op = CNT_INC;
					state_d    = S_DONE;
				end
			end
			S_OS_MV: begin
				cmd.wr   = WR_MOVE;
				cmd.j_op = J_DEC;
				state_d  = S_OS_CHK;
			end
			// remove range
			S_RM_CHK: begin
				if (sts.i_end) begin
					state_d = S_DONE;
					st_d    = ST_OK;
					src_d   = SRC_ZERO;
				end else begin
					cmd.rd  = RD_I;
					state_d = S_RM_EV;
				end
			end
			S_RM_EV: begin
				priority if (!sts.e_gt_addr) begin
					cmd.i_inc = 1'b1;
					state_d   = S_RM_CHK;
				end else if (sts.b_ge_lim) begin
					state_d = S_DONE;
					st_d    = ST_OK;
					src_d   = SRC_ZERO;
				end else if (sts.b_ge_addr && !sts.e_gt_lim) begin
					cmd.j_op = J_I;
					state_d  = S_CS_CHK;
				end else if (!sts.b_ge_addr && sts.e_gt_lim) begin
					// range inside one region: split it, or only trim it if the range ends past the address space
					st_d    = ST_OK;
					src_d   = SRC_ZERO;
					state_d = S_DONE;
					if (sts.lim_big) begin
						cmd.wr = WR_TRIM;
					end else if (sts.full) begin
						st_d = ST_FULL;
					end else begin
						cmd.wr   = WR_TRIM;
						cmd.ins  = INS_SPLIT;
						cmd.j_op = J_CNT;
						state_d  = S_OS_CHK;
					end
				end else if (!sts.b_ge_addr) begin
					cmd.wr    = WR_TRIM;
					cmd.i_inc = 1'b1;
					state_d   = S_RM_CHK;
				end else if (sts.lim_big) begin
					cmd.j_op = J_I;
					state_d  = S_CS_CHK;
				end else begin
					cmd.wr    = WR_CUT;
					cmd.i_inc = 1'b1;
					state_d   = S_RM_CHK;
				end
			end
			// close a slot: shift entries down one at a time
			S_CS_CHK: begin
				if (sts.jp1_lt_cnt) begin
					cmd.rd  = RD_JP1;
					state_d = S_CS_MV;
				end else begin
					cmd.cnt_op = CNT_DEC;
					state_d    = S_RM_CHK;
				end
			end
			S_CS_MV: begin
				cmd.wr   = WR_MOVE;
				cmd.j_op = J_INC;
				state_d  = S_CS_CHK;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
			src_q   <= SRC_ZERO;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			src_q   <= src_d;
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == S_IDLE))
		else $error("request loaded outside idle");

	a_done_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_we |=> (state_q == S_IDLE))
		else $error("result issued without returning to idle");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr == WR_MOVE) |-> $past(cmd.rd == RD_JM1 || cmd.rd == RD_JP1))
		else $error("entry move without preceding read");

endmodule

/* rtl/region_table_manager_core.sv */
// ----------------------------------------------------------------------------
// region_table_manager_core
// sorted region table with find, insert, first-fit insert, remove, validate
// ----------------------------------------------------------------------------
// request time grows with the table entries compared and with the entries shifted
//   while a slot is opened or closed; a remove that clears a full table is the longest
// throughput: one request at a time; the table walk through its single read port sets the rate
// result sits in an output register, the next request is taken while it waits
// reset: asynchronous, clears region count, sequencer and output valid;
//   low_limit resets to 0x1000 and high_limit to 0x800000000000
module region_table_manager_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// address[47:0], length[96:48], region_flags_in[98:97], zero pad above
	input  logic [rtm_pkg::IN_TW-1:0]   s_tdata,
	// kind[2:0]
	input  logic [rtm_pkg::KIND_W-1:0]  s_tuser,
	// result channel
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// status[2:0], found_begin[50:3], found_length[99:51], found_flags[101:100]
	output logic [rtm_pkg::OUT_TW-1:0]  m_tdata,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rtm_pkg::CFG_AW-1:0]  paddr,
	input  logic [rtm_pkg::CFG_DW-1:0]  pwdata,
	output logic [rtm_pkg::CFG_DW-1:0]  prdata,
	output logic                        pready
);
	import rtm_pkg::*;

	logic [ADDR_W-1:0] low_limit;
	logic [LEN_W-1:0]  high_limit;
	cmd_t              cmd;
	sts_t              sts;

	// placement limits
	rtm_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.low_limit  (low_limit),
		.high_limit (high_limit)
	);

	// sequencer: accepts a request only when idle
	rtm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table, compares and result register
	rtm_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_kind    (s_tuser),
		.in_data    (s_tdata),
		.low_limit  (low_limit),
		.high_limit (high_limit),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

endmodule

/* tb/region_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_table_checker
// watches the request, result and configuration channels, keeps its own
// copy of the region table and compares every result with its prediction
// ----------------------------------------------------------------------------
module region_table_checker
	import rtm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [IN_TW-1:0]     s_tdata,
	input  logic [KIND_W-1:0]    s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [OUT_TW-1:0]    m_tdata,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [CFG_AW-1:0]    paddr,
	input  logic [CFG_DW-1:0]    pwdata,
	input  logic                 pready,
	output int                   fail_count,
	output int                   pending
);

	localparam logic [63:0] ADDR_MAX  = (64'd1 << ADDR_W) - 64'd1;
	localparam logic [63:0] LEN_MAX   = (64'd1 << LEN_W) - 64'd1;
	localparam logic [63:0] PAGE_LOW  = (64'd1 << PAGE_BITS) - 64'd1;
	localparam logic [CFG_AW-1:0] REG_LOW  = 4'd0;
	localparam logic [CFG_AW-1:0] REG_HIGH = 4'd8;

	typedef struct {
		logic [ST_W-1:0]   st;
		logic [ADDR_W-1:0] rbegin;
		logic [LEN_W-1:0]  rlen;
		logic [FLAG_W-1:0] rflags;
	} region_result_t;

	region_result_t expected_results[$];

	logic [63:0] tbl_begin [MAX_REGIONS];
	logic [63:0] tbl_len   [MAX_REGIONS];
	logic [63:0] tbl_flags [MAX_REGIONS];
	int          tbl_count;
	logic [63:0] low_lim;
	logic [63:0] high_lim;

	function automatic logic [63:0] end_at(int i);
		return tbl_begin[i] + tbl_len[i];
	endfunction

	task automatic open_entry(int pos, logic [63:0] b, logic [63:0] l, logic [63:0] f);
		int i;
		for (i = tbl_count; i > pos; i--) begin
			tbl_begin[i] = tbl_begin[i-1];
			tbl_len[i]   = tbl_len[i-1];
			tbl_flags[i] = tbl_flags[i-1];
		end
		tbl_begin[pos] = b;
		tbl_len[pos]   = l;
		tbl_flags[pos] = f;
		tbl_count++;
	endtask

	task automatic drop_entry(int pos);
		int i;
		for (i = pos; i + 1 < tbl_count; i++) begin
			tbl_begin[i] = tbl_begin[i+1];
			tbl_len[i]   = tbl_len[i+1];
			tbl_flags[i] = tbl_flags[i+1];
		end
		tbl_count--;
	endtask

	function automatic int region_holding(logic [63:0] a);
		int i;
		for (i = 0; i < tbl_count; i++) begin
			if (tbl_begin[i] > a)
				return tbl_count;
			if (end_at(i) > a)
				return i;
		end
		return tbl_count;
	endfunction

	// applies one request to the table copy and returns the expected answer
	task automatic apply_request(input logic [KIND_W-1:0] kind, input logic [63:0] addr,
			input logic [63:0] len, input logic [63:0] fl, output region_result_t r);
		int i;
		logic [63:0] lim, cand, b, e, base, rest;
		logic [ST_W-1:0] st;
		bit done;
		r.st = ST_OK;
		r.rbegin = '0;
		r.rlen = '0;
		r.rflags = '0;
		lim = addr + len;
		done = 0;
		case (kind)
			KIND_FIND: begin
				i = region_holding(addr);
				if (i >= tbl_count)
					r.st = ST_MISS;
				else begin
					r.rbegin = tbl_begin[i][ADDR_W-1:0];
					r.rlen = tbl_len[i][LEN_W-1:0];
					r.rflags = tbl_flags[i][FLAG_W-1:0];
				end
			end
			KIND_INS_AT: begin
				if (addr & PAGE_LOW)
					r.st = ST_ALIGN;
				else begin
					for (i = 0; i < tbl_count; i++) begin
						if (tbl_begin[i] >= lim)
							break;
						if (end_at(i) > addr) begin
							done = 1;
							break;
						end
					end
					if (done)
						r.st = ST_OVERLAP;
					else if (tbl_count >= MAX_REGIONS)
						r.st = ST_FULL;
					else begin
						open_entry(i, addr, len, fl);
						r.rbegin = addr[ADDR_W-1:0];
						r.rlen = len[LEN_W-1:0];
						r.rflags = fl[FLAG_W-1:0];
					end
				end
			end
			KIND_INS_ANY: begin
				cand = low_lim;
				for (i = 0; i < tbl_count; i++) begin
					if (tbl_begin[i] >= cand + len)
						break;
					cand = end_at(i);
				end
				if ((i >= tbl_count && high_lim < cand + len) || cand > ADDR_MAX)
					r.st = ST_NOSPACE;
				else if (tbl_count >= MAX_REGIONS)
					r.st = ST_FULL;
				else begin
					open_entry(i, cand, len, fl);
					r.rbegin = cand[ADDR_W-1:0];
					r.rlen = len[LEN_W-1:0];
					r.rflags = fl[FLAG_W-1:0];
				end
			end
			KIND_REMOVE: begin
				if ((addr & PAGE_LOW) || (len & PAGE_LOW))
					r.st = ST_ALIGN;
				else begin
					i = 0;
					while (i < tbl_count) begin
						b = tbl_begin[i];
						e = end_at(i);
						if (e <= addr) begin
							i++;
							continue;
						end
						if (b >= lim)
							break;
						if (b >= addr && e <= lim) begin
							drop_entry(i);
							continue;
						end
						if (b < addr && e > lim) begin
							// split: right half keeps the flags, dropped past the top
							if (lim > ADDR_MAX)
								tbl_len[i] = addr - b;
							else if (tbl_count >= MAX_REGIONS)
								r.st = ST_FULL;
							else begin
								tbl_len[i] = addr - b;
								open_entry(i + 1, lim, e - lim, tbl_flags[i]);
							end
							break;
						end
						if (b < addr)
							tbl_len[i] = addr - b;
						else if (lim > ADDR_MAX) begin
							drop_entry(i);
							continue;
						end else begin
							tbl_begin[i] = lim;
							tbl_len[i] = e - lim;
						end
						i++;
					end
				end
			end
			KIND_VALIDATE: begin
				base = addr;
				rest = len;
				st = ST_OK;
				i = region_holding(base);
				while (1) begin
					if (i >= tbl_count || tbl_begin[i] > base) begin
						st = ST_MISS;
						break;
					end
					e = end_at(i);
					if (e - base >= rest)
						break;
					rest = rest - (e - base);
					base = e;
					i++;
					if (rest == 0)
						break;
				end
				r.st = st;
			end
			default: r.st = ST_MISS;
		endcase
	endtask

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		region_result_t r, got;
		int errs;
		if (!arst_n) begin
			tbl_count = 0;
			low_lim = 64'(LOW_RESET);
			high_lim = 64'(HIGH_RESET);
			fail_count <= 0;
		end else begin
			errs = 0;
			if (psel && penable && pwrite && pready) begin
				if (paddr == REG_LOW)
					low_lim = pwdata & ADDR_MAX;
				else if (paddr == REG_HIGH)
					high_lim = pwdata & LEN_MAX;
			end
			if (s_tvalid && s_tready) begin
				apply_request(s_tuser, 64'(s_tdata[47:0]), 64'(s_tdata[96:48]),
					64'(s_tdata[98:97]), r);
				expected_results.push_back(r);
			end
			if (m_tvalid && m_tready) begin
				got.st = m_tdata[2:0];
				got.rbegin = m_tdata[50:3];
				got.rlen = m_tdata[99:51];
				got.rflags = m_tdata[101:100];
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: status %0d", got.st);
					errs++;
				end else begin
					r = expected_results.pop_front();
					if (got.st !== r.st) begin
						$error("status expected %0d actual %0d", r.st, got.st);
						errs++;
					end
					if (got.rbegin !== r.rbegin) begin
						$error("found_begin expected %h actual %h", r.rbegin, got.rbegin);
						errs++;
					end
					if (got.rlen !== r.rlen) begin
						$error("found_length expected %h actual %h", r.rlen, got.rlen);
						errs++;
					end
					if (got.rflags !== r.rflags) begin
						$error("found_flags expected %0d actual %0d", r.rflags, got.rflags);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives find, insert, first-fit insert, remove and validate requests into
// the region table with random gaps and result stalls, across several
// low/high limit settings; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb;
	import rtm_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int N_RANDOM    = 1320;
	localparam int N_PHASES    = 5;
	localparam logic [CFG_AW-1:0] REG_LOW  = 4'd0;
	localparam logic [CFG_AW-1:0] REG_HIGH = 4'd8;
	localparam logic [63:0] TOP_PAGE = 64'hFFFF_FFFF_F000;
	localparam logic [63:0] FULL_LEN = 64'h1_0000_0000_0000;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	// address[47:0], length[96:48], region_flags_in[98:97], zero pad above
	logic [IN_TW-1:0]    s_tdata;
	// kind[2:0]
	logic [KIND_W-1:0]   s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	// status[2:0], found_begin[50:3], found_length[99:51], found_flags[101:100]
	logic [OUT_TW-1:0]   m_tdata;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [CFG_AW-1:0]   paddr;
	logic [CFG_DW-1:0]   pwdata;
	logic [CFG_DW-1:0]   prdata;
	logic                pready;
	int                  fail_count;
	int                  pending;
	int                  cycles = 0;
	int                  results_seen;
	bit                  sender_burst;

	region_table_manager_core dut (.*);

	region_table_checker chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.fail_count, .pending
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// run limit, far above the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one request: optional gap, then hold valid until the handshake
	task automatic send_request(logic [KIND_W-1:0] kind, logic [63:0] addr,
			logic [63:0] len, logic [1:0] fl);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {5'd0, fl, len[48:0], addr[47:0]};
		@(posedge clk);
		while (!(s_tvalid && s_tready)) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_AW-1:0] a, logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// block goes idle: nothing outstanding, then let the walk finish
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// random request, mostly page-aligned in a small window so regions collide
	task automatic random_request();
		int sel;
		logic [63:0] addr, len;
		logic [KIND_W-1:0] kind;
		sel = $urandom_range(0, 99);
		if (sel < 18) kind = KIND_FIND;
		else if (sel < 38) kind = KIND_INS_AT;
		else if (sel < 58) kind = KIND_INS_ANY;
		else if (sel < 80) kind = KIND_REMOVE;
		else if (sel < 96) kind = KIND_VALIDATE;
		else kind = KIND_W'($urandom_range(5, 7));
		sel = $urandom_range(0, 99);
		if (sel < 70) addr = 64'($urandom_range(0, 255)) << PAGE_BITS;
		else if (sel < 80) addr = TOP_PAGE - (64'($urandom_range(0, 15)) << PAGE_BITS);
		else if (sel < 90) addr = {16'd0, 16'($urandom), $urandom};
		else addr = 64'($urandom_range(0, 255)) << PAGE_BITS | 64'($urandom_range(1, 4095));
		sel = $urandom_range(0, 99);
		if (sel < 70) len = 64'($urandom_range(1, 16)) << PAGE_BITS;
		else if (sel < 78) len = 0;
		else if (sel < 88) len = {15'd0, 17'($urandom), $urandom};
		else if (sel < 92) len = FULL_LEN;
		else len = 64'($urandom_range(1, 65535));
		send_request(kind, addr, len, 2'($urandom));
	endtask

	// receiver: per-result stall, one long hold-off to back up the input
	initial begin
		int n;
		bit held;
		m_tready = 1'b0;
		held = 0;
		results_seen = 0;
		@(posedge arst_n);
		forever begin
			n = (results_seen % 200 < 60) ? 0 : $urandom_range(0, 13);
			if (!held && results_seen == 300) begin
				held = 1;
				n = 500;
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(m_tvalid && m_tready)) @(posedge clk);
			results_seen++;
		end
	end

	initial begin
		logic [63:0] lows [N_PHASES];
		logic [63:0] highs [N_PHASES];
		int p, k;
		lows = '{64'h1000, 64'h0, 64'hFFFF_FFFF_FFFF, 64'h3000, 64'h20000};
		highs = '{64'h8000_0000_0000, FULL_LEN, FULL_LEN, 64'h40000, 64'h0};
		sender_burst = 0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset limits
		send_request(KIND_FIND, 64'h0, 64'h0, 2'd0);             // empty table miss
		send_request(KIND_INS_AT, 64'h1001, 64'h1000, 2'd1);     // misaligned insert
		send_request(KIND_INS_AT, 64'h10000, 64'h4000, 2'd3);
		send_request(KIND_INS_AT, 64'h12000, 64'h1000, 2'd0);    // overlap
		send_request(KIND_INS_ANY, 64'h0, 64'h2000, 2'd1);       // lands at low limit
		send_request(KIND_INS_ANY, 64'h0, 64'h0, 2'd2);          // zero length
		send_request(KIND_INS_AT, 64'h20000, 64'h1234, 2'd2);    // unaligned length ok
		send_request(KIND_FIND, 64'h13fff, 64'h0, 2'd0);
		send_request(KIND_FIND, 64'h14000, 64'h0, 2'd0);
		send_request(KIND_VALIDATE, 64'h1000, 64'h0, 2'd0);      // zero length in region
		send_request(KIND_VALIDATE, 64'h1000, 64'h13000, 2'd0);  // gap
		send_request(KIND_VALIDATE, 64'h10000, 64'h4000, 2'd0);
		send_request(KIND_REMOVE, 64'h11000, 64'h1000, 2'd0);    // split keeps flags
		send_request(KIND_FIND, 64'h12000, 64'h0, 2'd0);
		send_request(KIND_REMOVE, 64'h1001, 64'h1000, 2'd0);     // misaligned base
		send_request(KIND_REMOVE, 64'h1000, 64'h800, 2'd0);      // misaligned length
		send_request(KIND_INS_AT, TOP_PAGE, FULL_LEN, 2'd3);     // top of address space
		send_request(KIND_REMOVE, TOP_PAGE, 64'h1000, 2'd0);     // remainder past the top
		send_request(KIND_INS_AT, TOP_PAGE - 64'h1000, 64'h4000, 2'd1);
		send_request(KIND_REMOVE, TOP_PAGE, 64'h1000, 2'd0);     // split past the top trims
		send_request(KIND_INS_ANY, 64'h0, FULL_LEN, 2'd3);       // no space at table end
		send_request(3'd5, 64'h0, 64'h0, 2'd0);                  // unknown kinds
		send_request(3'd6, 64'h0, 64'h0, 2'd0);
		send_request(3'd7, {16'd0, 48'hFFFF_FFFF_FFFF}, {15'd0, 49'h1_FFFF_FFFF_FFFF}, 2'd3);
		drain();

		// random phases, limits rewritten while idle
		for (p = 0; p < N_PHASES; p++) begin
			write_reg(REG_LOW, lows[p]);
			write_reg(REG_HIGH, highs[p]);
			for (k = 0; k < N_RANDOM / N_PHASES; k++) begin
				sender_burst = (k % 80) < 20;
				random_request();
			end
			drain();
		end

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
